// ----- hw/rtl/dnd_pkg.sv -----
// ----------------------------------------------------------------------------
// dnd_pkg
// Shared types and constants for the DNS name decompression block.
// ----------------------------------------------------------------------------
package dnd_pkg;

    localparam int MSG_DEPTH = 4096;
    localparam int MSG_AW    = $clog2(MSG_DEPTH);
    localparam int LEN_W     = MSG_AW + 1;
    localparam int PTR_W     = 14;
    localparam int ITER_W    = MSG_AW;

    localparam int NAME_MAX  = 254;
    localparam int NAME_AW   = 8;
    localparam int LANES     = 8;
    localparam int LANE_AW   = $clog2(LANES);
    localparam int ROW_AW    = NAME_AW - LANE_AW;
    localparam int NAME_ROWS = 1 << ROW_AW;

    localparam logic       ACT_LOAD   = 1'b0;
    localparam logic       ACT_EXPAND = 1'b1;
    localparam logic       STATUS_OK  = 1'b0;
    localparam logic       STATUS_ERR = 1'b1;
    localparam logic [7:0] DOT_CHAR   = 8'h2e;

    typedef struct packed {
        logic        action;
        logic [11:0] byte_addr;
        logic [7:0]  byte_value;
        logic [12:0] msg_len;
        logic [7:0]  out_space;
    } in_word_t;

    typedef struct packed {
        logic [63:0] name_bytes;
        logic [3:0]  byte_count;
        logic        last;
        logic        status;
        logic [12:0] consumed;
    } out_word_t;

    typedef struct packed {
        logic               en;
        logic [NAME_AW-1:0] addr;
        logic [7:0]         data;
    } nb_wr_t;

endpackage

// ----- hw/rtl/dnd_ram.sv -----
// ----------------------------------------------------------------------------
// dnd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dnd_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/dnd_name_buf.sv -----
// ----------------------------------------------------------------------------
// dnd_name_buf
// Name buffer: byte-wide writes, 8-byte row reads with registered data.
// ----------------------------------------------------------------------------
module dnd_name_buf (
    input  logic                      aclk,
    input  dnd_pkg::nb_wr_t           wr,
    input  logic [dnd_pkg::ROW_AW-1:0] rd_row,
    output logic [63:0]               rd_data
);

    logic [63:0] mem [dnd_pkg::NAME_ROWS];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr[dnd_pkg::NAME_AW-1:dnd_pkg::LANE_AW]]
                [{wr.addr[dnd_pkg::LANE_AW-1:0], 3'b000} +: 8] <= wr.data;
        end
        rd_data <= mem[rd_row];
    end

endmodule

// ----- hw/rtl/dnd_walk.sv -----
// ----------------------------------------------------------------------------
// dnd_walk
// Label/pointer walker, name chunk emitter and output register.
// ----------------------------------------------------------------------------
module dnd_walk (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  dnd_pkg::in_word_t          s_data,
    output logic [dnd_pkg::MSG_AW-1:0] msg_raddr,
    input  logic [7:0]                 msg_rdata,
    output dnd_pkg::nb_wr_t            nb_wr,
    output logic [dnd_pkg::ROW_AW-1:0] nb_rrow,
    input  logic [63:0]                nb_rdata,
    output logic                       m_valid,
    input  logic                       m_ready,
    output dnd_pkg::out_word_t         m_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_PTR,
        ST_COPY,
        ST_OUT,
        ST_ERR
    } state_t;

    state_t                         state_reg, state_next;
    logic [dnd_pkg::MSG_AW-1:0]     p_reg, p_next;
    logic [dnd_pkg::MSG_AW-1:0]     start_reg, start_next;
    logic [dnd_pkg::LEN_W-1:0]      mlen_reg, mlen_next;
    logic [dnd_pkg::NAME_AW-1:0]    cap_reg, cap_next;
    logic [dnd_pkg::NAME_AW-1:0]    d_reg, d_next;
    logic [dnd_pkg::ITER_W-1:0]     iter_reg, iter_next;
    logic                           have_len_reg, have_len_next;
    logic [dnd_pkg::LEN_W-1:0]      len_reg, len_next;
    logic [5:0]                     hi_reg, hi_next;
    logic [5:0]                     cnt_reg, cnt_next;
    logic [dnd_pkg::ROW_AW-1:0]     k_reg, k_next;
    logic                           m_valid_reg, m_valid_next;
    dnd_pkg::out_word_t             m_data_reg, m_data_next;

    logic [dnd_pkg::LEN_W-1:0]      mlen_in;
    logic [dnd_pkg::NAME_AW-1:0]    cap_in;
    logic [dnd_pkg::LEN_W-1:0]      p_inc;
    logic [dnd_pkg::LEN_W-1:0]      rem_msg;
    logic [dnd_pkg::NAME_AW-1:0]    d_dot;
    logic [dnd_pkg::NAME_AW-1:0]    rem_cap;
    logic [dnd_pkg::PTR_W-1:0]      target;
    logic [dnd_pkg::LEN_W:0]        iter_init;
    logic [dnd_pkg::NAME_AW-1:0]    rem_name;
    logic [3:0]                     cnt_out;
    logic                           chunk_last;
    logic [63:0]                    chunk;
    logic                           out_free;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        mlen_in   = (s_data.msg_len > dnd_pkg::LEN_W'(dnd_pkg::MSG_DEPTH)) ?
                    dnd_pkg::LEN_W'(dnd_pkg::MSG_DEPTH) : s_data.msg_len;
        cap_in    = (s_data.out_space > dnd_pkg::NAME_AW'(dnd_pkg::NAME_MAX)) ?
                    dnd_pkg::NAME_AW'(dnd_pkg::NAME_MAX) : s_data.out_space;
        iter_init = ({1'b0, mlen_in} + (dnd_pkg::LEN_W + 1)'(1)) >> 1;
        p_inc     = {1'b0, p_reg} + dnd_pkg::LEN_W'(1);
        rem_msg   = mlen_reg - p_inc;
        d_dot     = d_reg + dnd_pkg::NAME_AW'(d_reg != '0);
        rem_cap   = cap_reg - d_dot;
        target    = {hi_reg, msg_rdata};
        rem_name  = d_reg - {k_reg, 3'b000};
        cnt_out   = (rem_name > 8'd8) ? 4'd8 : rem_name[3:0];
        chunk_last = (rem_name <= 8'd8);
        for (int i = 0; i < dnd_pkg::LANES; i++) begin
            chunk[i*8 +: 8] = (4'(i) < cnt_out) ? nb_rdata[i*8 +: 8] : 8'h00;
        end

        state_next    = state_reg;
        p_next        = p_reg;
        start_next    = start_reg;
        mlen_next     = mlen_reg;
        cap_next      = cap_reg;
        d_next        = d_reg;
        iter_next     = iter_reg;
        have_len_next = have_len_reg;
        len_next      = len_reg;
        hi_next       = hi_reg;
        cnt_next      = cnt_reg;
        k_next        = k_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        msg_raddr     = p_reg;
        nb_rrow       = k_reg;
        nb_wr.en      = 1'b0;
        nb_wr.addr    = d_reg;
        nb_wr.data    = msg_rdata;

        unique case (state_reg)
            ST_IDLE: begin
                msg_raddr = s_data.byte_addr;
                if (s_valid && s_data.action == dnd_pkg::ACT_EXPAND) begin
                    mlen_next     = mlen_in;
                    cap_next      = cap_in;
                    p_next        = s_data.byte_addr;
                    start_next    = s_data.byte_addr;
                    d_next        = '0;
                    have_len_next = 1'b0;
                    iter_next     = iter_init[dnd_pkg::ITER_W-1:0];
                    if ({1'b0, s_data.byte_addr} >= mlen_in || s_data.out_space == '0) begin
                        state_next = ST_ERR;
                    end else begin
                        state_next = ST_HEAD;
                    end
                end
            end
            ST_HEAD: begin
                if (iter_reg == '0) begin
                    state_next = ST_ERR;
                end else begin
                    iter_next = iter_reg - dnd_pkg::ITER_W'(1);
                    if (msg_rdata[7:6] != 2'b00) begin
                        hi_next = msg_rdata[5:0];
                        if (!have_len_reg) begin
                            have_len_next = 1'b1;
                            len_next = p_inc + dnd_pkg::LEN_W'(1) - {1'b0, start_reg};
                        end
                        msg_raddr = p_inc[dnd_pkg::MSG_AW-1:0];
                        if (p_inc == mlen_reg) begin
                            state_next = ST_ERR;
                        end else begin
                            state_next = ST_PTR;
                        end
                    end else if (msg_rdata != 8'h00) begin
                        if (d_reg != '0) begin
                            nb_wr.en   = 1'b1;
                            nb_wr.data = dnd_pkg::DOT_CHAR;
                        end
                        d_next    = d_dot;
                        cnt_next  = msg_rdata[5:0];
                        p_next    = p_inc[dnd_pkg::MSG_AW-1:0];
                        msg_raddr = p_inc[dnd_pkg::MSG_AW-1:0];
                        if (dnd_pkg::LEN_W'(msg_rdata[5:0]) >= rem_msg ||
                            dnd_pkg::NAME_AW'(msg_rdata[5:0]) >= rem_cap) begin
                            state_next = ST_ERR;
                        end else begin
                            state_next = ST_COPY;
                        end
                    end else begin
                        if (!have_len_reg) begin
                            len_next = p_inc - {1'b0, start_reg};
                        end
                        k_next     = '0;
                        nb_rrow    = '0;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_PTR: begin
                p_next    = target[dnd_pkg::MSG_AW-1:0];
                msg_raddr = target[dnd_pkg::MSG_AW-1:0];
                if (target >= dnd_pkg::PTR_W'(mlen_reg)) begin
                    state_next = ST_ERR;
                end else begin
                    state_next = ST_HEAD;
                end
            end
            ST_COPY: begin
                nb_wr.en  = 1'b1;
                d_next    = d_reg + dnd_pkg::NAME_AW'(1);
                p_next    = p_inc[dnd_pkg::MSG_AW-1:0];
                msg_raddr = p_inc[dnd_pkg::MSG_AW-1:0];
                cnt_next  = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    state_next = ST_HEAD;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.name_bytes = chunk;
                    m_data_next.byte_count = cnt_out;
                    m_data_next.last       = chunk_last;
                    m_data_next.status     = dnd_pkg::STATUS_OK;
                    m_data_next.consumed   = chunk_last ? len_reg : '0;
                    if (chunk_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next  = k_reg + dnd_pkg::ROW_AW'(1);
                        nb_rrow = k_reg + dnd_pkg::ROW_AW'(1);
                    end
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.name_bytes = '0;
                    m_data_next.byte_count = '0;
                    m_data_next.last       = 1'b1;
                    m_data_next.status     = dnd_pkg::STATUS_ERR;
                    m_data_next.consumed   = '0;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        p_reg        <= p_next;
        start_reg    <= start_next;
        mlen_reg     <= mlen_next;
        cap_reg      <= cap_next;
        d_reg        <= d_next;
        iter_reg     <= iter_next;
        have_len_reg <= have_len_next;
        len_reg      <= len_next;
        hi_reg       <= hi_next;
        cnt_reg      <= cnt_next;
        k_reg        <= k_next;
        m_data_reg   <= m_data_next;
    end

endmodule

// ----- hw/rtl/dns_name_decompress_top.sv -----
// Load words: one per cycle, accepted back to back, no result.
// Expand words: the walker reads each label, root or pointer head, the low byte
// of each pointer, and each label byte copied, then emits the 8-byte output
// words (an error gives a single word). The single read port of the message store
// sets the walk rate. Input stalls until the last word is registered.
// Reset clears control only; message store and name buffer are not cleared.
// ----------------------------------------------------------------------------
// dns_name_decompress_top
// DNS name decompression: message store, walker and name buffer.
// ----------------------------------------------------------------------------
module dns_name_decompress_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dnd_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output dnd_pkg::out_word_t m_data
);

    logic                       msg_we;
    logic [dnd_pkg::MSG_AW-1:0] msg_raddr;
    logic [7:0]                 msg_rdata;
    dnd_pkg::nb_wr_t            nb_wr;
    logic [dnd_pkg::ROW_AW-1:0] nb_rrow;
    logic [63:0]                nb_rdata;

    assign msg_we = s_valid && s_ready && (s_data.action == dnd_pkg::ACT_LOAD);

    dnd_ram #(
        .DEPTH (dnd_pkg::MSG_DEPTH),
        .WIDTH (8)
    ) u_msg_ram (
        .aclk  (aclk),
        .we    (msg_we),
        .waddr (s_data.byte_addr),
        .wdata (s_data.byte_value),
        .raddr (msg_raddr),
        .rdata (msg_rdata)
    );

    dnd_name_buf u_name_buf (
        .aclk    (aclk),
        .wr      (nb_wr),
        .rd_row  (nb_rrow),
        .rd_data (nb_rdata)
    );

    dnd_walk u_walk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .msg_raddr (msg_raddr),
        .msg_rdata (msg_rdata),
        .nb_wr     (nb_wr),
        .nb_rrow   (nb_rrow),
        .nb_rdata  (nb_rdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    a_expand_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.action == dnd_pkg::ACT_EXPAND |=> !s_ready)
        else $error("expand word did not stall input");

    a_err_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == dnd_pkg::STATUS_ERR |->
            m_data.last && m_data.byte_count == 4'd0 && m_data.consumed == '0)
        else $error("malformed error word");

    a_full_chunk: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |->
            m_data.byte_count == 4'd8 && m_data.consumed == '0)
        else $error("non-final word not full");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.byte_count <= 4'd8)
        else $error("byte count out of range");

endmodule

// ----- bench/tb_dns_name_decompress_top.sv -----
// ----------------------------------------------------------------------------
// tb_dns_name_decompress_top
// Self-checking bench for the DNS name decompressor. Message bytes are
// loaded and names are expanded from them. A shadow copy of the message
// store predicts every output word, and each word is checked field by field
// as it leaves the block. Both sides idle at random. The receiver also holds
// off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------

class name_expander;
    logic [7:0]         msg_copy [dnd_pkg::MSG_DEPTH];
    bit                 msg_set  [dnd_pkg::MSG_DEPTH];
    logic [7:0]         text     [dnd_pkg::NAME_MAX];
    dnd_pkg::out_word_t words_due [$];
    int                 fails;
    int                 words_made;

    function new();
        foreach (msg_copy[i]) begin
            msg_copy[i] = '0;
            msg_set[i]  = 1'b0;
        end
        foreach (text[i]) text[i] = '0;
        fails      = 0;
        words_made = 0;
    endfunction

    function int pending();
        return words_due.size();
    endfunction

    // label/pointer walk; dirty flags any read of a byte never loaded
    function bit follow_labels(input int start, input int mlen, input int cap,
                               output int nlen, output int used, output bit dirty);
        int         p, d, len, cnt, target, step;
        bit         have_len;
        logic [7:0] b;
        p = start;
        d = 0;
        len = 0;
        have_len = 1'b0;
        nlen = 0;
        used = 0;
        dirty = 1'b0;
        for (step = 0; step < mlen; step += 2) begin
            dirty |= !msg_set[p];
            b = msg_copy[p];
            if (b[7:6] != 2'b00) begin
                if (p + 1 == mlen) return 1'b0;
                dirty |= !msg_set[p + 1];
                target = int'({b[5:0], msg_copy[p + 1]});
                if (!have_len) begin
                    len = p + 2 - start;
                    have_len = 1'b1;
                end
                if (target >= mlen) return 1'b0;
                p = target;
            end else if (b != 8'h00) begin
                cnt = int'(b);
                if (d != 0) begin
                    text[d] = dnd_pkg::DOT_CHAR;
                    d++;
                end
                p++;
                if (cnt >= mlen - p || cnt >= cap - d) return 1'b0;
                repeat (cnt) begin
                    dirty |= !msg_set[p];
                    text[d] = msg_copy[p];
                    d++;
                    p++;
                end
            end else begin
                if (!have_len) len = p + 1 - start;
                nlen = d;
                used = len;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function bit reads_known(dnd_pkg::in_word_t w);
        int mlen, cap, nlen, used;
        bit dirty;
        mlen = (w.msg_len > dnd_pkg::MSG_DEPTH) ? dnd_pkg::MSG_DEPTH : int'(w.msg_len);
        cap  = (w.out_space > dnd_pkg::NAME_MAX) ? dnd_pkg::NAME_MAX : int'(w.out_space);
        if (w.byte_addr >= mlen || cap == 0) return 1'b1;
        void'(follow_labels(int'(w.byte_addr), mlen, cap, nlen, used, dirty));
        return !dirty;
    endfunction

    function void take_word(dnd_pkg::in_word_t w);
        int                 mlen, cap, nlen, used, chunks, cnt, k, i;
        bit                 dirty, ok;
        dnd_pkg::out_word_t e;
        if (w.action == dnd_pkg::ACT_LOAD) begin
            msg_copy[w.byte_addr] = w.byte_value;
            msg_set[w.byte_addr]  = 1'b1;
            return;
        end
        mlen = (w.msg_len > dnd_pkg::MSG_DEPTH) ? dnd_pkg::MSG_DEPTH : int'(w.msg_len);
        cap  = (w.out_space > dnd_pkg::NAME_MAX) ? dnd_pkg::NAME_MAX : int'(w.out_space);
        ok = (w.byte_addr < mlen) && (cap != 0);
        if (ok) ok = follow_labels(int'(w.byte_addr), mlen, cap, nlen, used, dirty);
        if (!ok) begin
            e = '0;
            e.last   = 1'b1;
            e.status = dnd_pkg::STATUS_ERR;
            words_due.push_back(e);
            words_made++;
            return;
        end
        chunks = (nlen == 0) ? 1 : (nlen + 7) / 8;
        for (k = 0; k < chunks; k++) begin
            e = '0;
            cnt = nlen - k * dnd_pkg::LANES;
            if (cnt > dnd_pkg::LANES) cnt = dnd_pkg::LANES;
            for (i = 0; i < cnt; i++)
                e.name_bytes[8*i +: 8] = text[k * dnd_pkg::LANES + i];
            e.byte_count = 4'(cnt);
            e.last       = (k == chunks - 1);
            e.status     = dnd_pkg::STATUS_OK;
            e.consumed   = e.last ? 13'(used) : '0;
            words_due.push_back(e);
            words_made++;
        end
    endfunction

    task report(string what);
        fails++;
        if (fails <= 100) $display("MISMATCH %0d: %s", fails, what);
    endtask

    task check_word(dnd_pkg::out_word_t got);
        dnd_pkg::out_word_t e;
        if (words_due.size() == 0) begin
            report($sformatf("word with nothing pending: %h", got));
            return;
        end
        e = words_due.pop_front();
        if (got.name_bytes !== e.name_bytes)
            report($sformatf("name_bytes %h, want %h", got.name_bytes, e.name_bytes));
        if (got.byte_count !== e.byte_count)
            report($sformatf("byte_count %0d, want %0d", got.byte_count, e.byte_count));
        if (got.last !== e.last)
            report($sformatf("last %b, want %b", got.last, e.last));
        if (got.status !== e.status)
            report($sformatf("status %b, want %b", got.status, e.status));
        if (got.consumed !== e.consumed)
            report($sformatf("consumed %0d, want %0d", got.consumed, e.consumed));
    endtask
endclass

module tb_dns_name_decompress_top;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    dnd_pkg::in_word_t  s_data;
    logic               m_valid;
    logic               m_ready;
    dnd_pkg::out_word_t m_data;

    name_expander book;
    int           sent_count;
    int           src_idle_pct;
    int           snk_idle_pct;
    bit           hold_active;
    event         hold_go;
    int           name_starts [$];

    dns_name_decompress_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        hold_active = 1'b0;
        @(hold_go);
        @(posedge aclk);
        hold_active = 1'b1;
        repeat (400) @(posedge aclk);
        hold_active = 1'b0;
    end

    always @(negedge aclk) begin
        if (hold_active)
            m_ready = 1'b0;
        else
            m_ready = ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) book.check_word(m_data);
    end

    initial begin
        #(8 * 3_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    // entered and left at a falling edge
    task send_word(dnd_pkg::in_word_t w);
        while ($urandom_range(0, 99) < src_idle_pct) @(negedge aclk);
        s_valid = 1'b1;
        s_data  = w;
        do @(posedge aclk); while (!s_ready);
        book.take_word(w);
        sent_count++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task load_byte(input int addr, input int val);
        dnd_pkg::in_word_t w;
        w.action     = dnd_pkg::ACT_LOAD;
        w.byte_addr  = 12'(addr);
        w.byte_value = 8'(val);
        w.msg_len    = 13'($urandom_range(0, 8191));
        w.out_space  = 8'($urandom_range(0, 255));
        send_word(w);
    endtask

    task send_expand(input int addr, input int mlen, input int space);
        dnd_pkg::in_word_t w;
        w.action     = dnd_pkg::ACT_EXPAND;
        w.byte_addr  = 12'(addr);
        w.byte_value = 8'($urandom_range(0, 255));
        w.msg_len    = 13'(mlen);
        w.out_space  = 8'(space);
        // walk would touch unloaded bytes: turn it into a bad start
        if (!book.reads_known(w)) w.msg_len = {1'b0, w.byte_addr};
        send_word(w);
    endtask

    task write_label(inout int p, input int len);
        load_byte(p, len);
        p++;
        repeat (len) begin
            load_byte(p, $urandom_range(0, 255));
            p++;
        end
    endtask

    task build_name(output int base, output int stop);
        int p, nlab, tgt;
        nlab = $urandom_range(0, 4);
        base = $urandom_range(0, dnd_pkg::MSG_DEPTH - 140);
        p = base;
        repeat (nlab)
            write_label(p, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 30)
                                                         : $urandom_range(1, 12));
        if (name_starts.size() != 0 && $urandom_range(0, 1) == 1) begin
            tgt = name_starts[$urandom_range(0, name_starts.size() - 1)];
            load_byte(p, ($urandom_range(1, 3) << 6) | (tgt >> 8));
            load_byte(p + 1, tgt & 8'hff);
            p += 2;
        end else begin
            load_byte(p, 0);
            p++;
        end
        name_starts.push_back(base);
        stop = p;
    endtask

    function int pick_len(int base, int stop);
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return $urandom_range(dnd_pkg::MSG_DEPTH, 8191);
        if (r < 85) return $urandom_range(stop, dnd_pkg::MSG_DEPTH);
        return $urandom_range(base + 1, stop);
    endfunction

    function int pick_space();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 24);
        return $urandom_range(40, 255);
    endfunction

    task random_traffic(input int n_items, input int n_words);
        int first_item, first_word, base, stop, pick, addr;
        first_item = sent_count;
        first_word = book.words_made;
        while (sent_count - first_item < n_items || book.words_made - first_word < n_words) begin
            pick = $urandom_range(0, 99);
            if (pick < 30 || name_starts.size() == 0) begin
                build_name(base, stop);
                send_expand(base, pick_len(base, stop), pick_space());
            end else if (pick < 70) begin
                base = name_starts[$urandom_range(0, name_starts.size() - 1)];
                send_expand(base, pick_len(base, base + 1), pick_space());
            end else if (pick < 82) begin
                if ($urandom_range(0, 1) == 1)
                    addr = $urandom_range(0, dnd_pkg::MSG_DEPTH - 1);
                else
                    addr = name_starts[$urandom_range(0, name_starts.size() - 1)]
                           + $urandom_range(0, 20);
                if (addr > dnd_pkg::MSG_DEPTH - 1) addr = dnd_pkg::MSG_DEPTH - 1;
                send_expand(addr, $urandom_range(0, 8191), $urandom_range(0, 255));
            end else begin
                repeat ($urandom_range(1, 3))
                    load_byte($urandom_range(0, dnd_pkg::MSG_DEPTH - 1),
                              $urandom_range(0, 255));
            end
        end
    endtask

    initial begin
        int long_base, p;
        book         = new();
        sent_count   = 0;
        src_idle_pct = 15;
        snk_idle_pct = 15;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // "x" at 0, "yz" + pointer to 0 at 3, self pointer at 8, far pointer at 10
        load_byte(0, 8'h01);
        load_byte(1, 8'h78);
        load_byte(2, 8'h00);
        load_byte(3, 8'h02);
        load_byte(4, 8'h79);
        load_byte(5, 8'h7a);
        load_byte(6, 8'hc0);
        load_byte(7, 8'h00);
        load_byte(8, 8'hc0);
        load_byte(9, 8'h08);
        load_byte(10, 8'h80);
        load_byte(11, 8'h0c);
        send_expand(0, 10, 255);
        send_expand(3, 10, 254);
        send_expand(6, 10, 100);     // pointer only, consumed 2
        send_expand(2, 10, 1);       // root name
        send_expand(3, 10, 5);       // just fits
        send_expand(3, 10, 4);       // no room for terminator
        send_expand(0, 10, 0);       // zero space
        send_expand(10, 10, 200);    // start past message
        send_expand(6, 7, 100);      // pointer on last byte
        send_expand(10, 12, 100);    // pointer target past message
        send_expand(3, 5, 100);      // truncated label
        send_expand(8, 10, 100);     // pointer loop
        send_expand(0, 8191, 255);   // length clipped to store depth
        send_expand(8, 4096, 100);   // pointer loop, full-depth guard

        src_idle_pct = 0;
        snk_idle_pct = 0;
        random_traffic(25, 0);
        src_idle_pct = 15;
        snk_idle_pct = 15;

        // 22-character name, 3 output words
        long_base = $urandom_range(2048, dnd_pkg::MSG_DEPTH - 40);
        p = long_base;
        write_label(p, 12);
        write_label(p, 9);
        load_byte(p, 0);
        name_starts.push_back(long_base);
        -> hold_go;
        send_expand(long_base, $urandom_range(dnd_pkg::MSG_DEPTH, 8191), 254);
        send_expand(long_base, dnd_pkg::MSG_DEPTH, 23);   // just fits
        send_expand(long_base, dnd_pkg::MSG_DEPTH, 22);   // one short
        random_traffic(25, 0);

        while (book.pending() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
        if (book.fails == 0 && book.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
